// File: design/e2g_pkg.sv
// e2g_pkg: shared constants, types and the CORDIC arctangent table for the
// ECEF to geodetic core. No dependencies.
`default_nettype none

package e2g_pkg;

   // defaults for top-level parameters
   localparam int MAX_ITERATIONS_DEF = 8;
   localparam int POS_WIDTH_DEF      = 42;

   // fixed-point formats
   localparam int FRAC_BITS    = 12;
   localparam int CORDIC_STEPS = 32;
   localparam int ANG_W        = 34;
   localparam int DIV_W        = 76;
   localparam int SQRT_STEPS   = 32;
   localparam int RADIUS_W     = 33;
   localparam int FLAT_W       = 32;
   localparam int CSR_IDX_W    = 8;

   localparam logic [32:0] INV_GAIN = 33'd2608131496;
   localparam logic [32:0] RADIUS_RESET = 33'd6378137000;
   localparam logic [31:0] FLAT_RESET   = 32'd14400212;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_RADIUS = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FLAT   = 8'd1;

   // divide / square-root unit operations
   localparam logic DS_DIV  = 1'b0;
   localparam logic DS_SQRT = 1'b1;

   typedef struct packed {
      logic start;
      logic frac;
   } mul_ctl_type;

   typedef struct packed {
      logic start;
      logic op;
   } ds_ctl_type;

   // atan(2^-i) as binary angle, 2^31 = pi
   function automatic logic [29:0] atan_entry(input logic [4:0] i);
      logic [29:0] v;
      case (i)
         5'd0:  v = 30'd536870912;
         5'd1:  v = 30'd316933406;
         5'd2:  v = 30'd167458907;
         5'd3:  v = 30'd85004756;
         5'd4:  v = 30'd42667331;
         5'd5:  v = 30'd21354465;
         5'd6:  v = 30'd10679838;
         5'd7:  v = 30'd5340245;
         5'd8:  v = 30'd2670163;
         5'd9:  v = 30'd1335087;
         5'd10: v = 30'd667544;
         5'd11: v = 30'd333772;
         5'd12: v = 30'd166886;
         5'd13: v = 30'd83443;
         5'd14: v = 30'd41722;
         5'd15: v = 30'd20861;
         5'd16: v = 30'd10430;
         5'd17: v = 30'd5215;
         5'd18: v = 30'd2608;
         5'd19: v = 30'd1304;
         5'd20: v = 30'd652;
         5'd21: v = 30'd326;
         5'd22: v = 30'd163;
         5'd23: v = 30'd81;
         5'd24: v = 30'd41;
         5'd25: v = 30'd20;
         5'd26: v = 30'd10;
         5'd27: v = 30'd5;
         5'd28: v = 30'd3;
         5'd29: v = 30'd1;
         5'd30: v = 30'd1;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// File: design/e2g_mul.sv
// e2g_mul: shared 32x33 multiplier, low 64 bits of a[31:0]*b or floor(a*b/2^32).
// Depends on e2g_pkg.
`default_nettype none

module e2g_mul (
   input  wire                 clock,
   input  wire                 reset,
   input  e2g_pkg::mul_ctl_type ctl,
   input  wire [63:0]          a_in,
   input  wire [32:0]          b_in,
   output logic                done,
   output logic [63:0]         result
);
   import e2g_pkg::*;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_LO   = 2'd1;
   localparam logic [1:0] PH_HI   = 2'd2;
   localparam logic [1:0] PH_SUM  = 2'd3;

   logic [1:0]  phase_ff;
   logic        frac_ff, done_ff;
   logic [63:0] a_ff, res_ff;
   logic [32:0] b_ff, lo_ff;
   logic [64:0] prod_ff, prod;
   logic [31:0] opa;

   // one multiplier, low half of a first, then high half in the fractional mode
   always_comb begin
      opa  = (phase_ff == PH_HI) ? a_ff[63:32] : a_ff[31:0];
      prod = 65'(opa) * 65'(b_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (phase_ff)
            PH_IDLE: begin
               if (ctl.start) begin
                  a_ff     <= a_in;
                  b_ff     <= b_in;
                  frac_ff  <= ctl.frac;
                  phase_ff <= PH_LO;
               end
            end
            PH_LO: begin
               prod_ff  <= prod;
               phase_ff <= frac_ff ? PH_HI : PH_SUM;
            end
            PH_HI: begin
               lo_ff    <= prod_ff[64:32];
               prod_ff  <= prod;
               phase_ff <= PH_SUM;
            end
            PH_SUM: begin
               res_ff   <= frac_ff ? prod_ff[63:0] + 64'(lo_ff) : prod_ff[63:0];
               done_ff  <= 1'b1;
               phase_ff <= PH_IDLE;
            end
            default: phase_ff <= PH_IDLE;
         endcase
      end
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

`default_nettype wire

// File: design/e2g_cordic.sv
// e2g_cordic: CORDIC vectoring engine, one micro-rotation per cycle,
// returns unscaled magnitude and angle. Depends on e2g_pkg.
`default_nettype none

module e2g_cordic (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   input  wire signed [63:0]                x_in,
   input  wire signed [63:0]                y_in,
   output logic                             done,
   output logic signed [63:0]               x_out,
   output logic signed [e2g_pkg::ANG_W-1:0] ang_out
);
   import e2g_pkg::*;

   localparam logic [4:0] STEP_LAST = 5'(CORDIC_STEPS - 1);
   localparam logic signed [ANG_W-1:0] ANG_PI = ANG_W'(64'sd1 <<< 31);

   logic signed [63:0]      x_ff, y_ff, dx, dy;
   logic signed [ANG_W-1:0] a_ff, tab;
   logic [4:0]              step_ff;
   logic                    busy_ff, done_ff;

   // shifted cross terms and table angle for this step
   always_comb begin
      dx  = y_ff >>> step_ff;
      dy  = x_ff >>> step_ff;
      tab = ANG_W'(atan_entry(step_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            step_ff <= '0;
            if (x_in == 64'sd0 && y_in == 64'sd0) begin
               x_ff    <= '0;
               y_ff    <= '0;
               a_ff    <= '0;
               done_ff <= 1'b1;
            end else if (x_in < 0) begin
               // left half plane: rotate by pi first
               x_ff    <= -x_in;
               y_ff    <= -y_in;
               a_ff    <= (y_in >= 0) ? ANG_PI : -ANG_PI;
               busy_ff <= 1'b1;
            end else begin
               x_ff    <= x_in;
               y_ff    <= y_in;
               a_ff    <= '0;
               busy_ff <= 1'b1;
            end
         end else if (busy_ff) begin
            if (y_ff > 0) begin
               x_ff <= x_ff + dx;
               y_ff <= y_ff - dy;
               a_ff <= a_ff + tab;
            end else begin
               x_ff <= x_ff - dx;
               y_ff <= y_ff + dy;
               a_ff <= a_ff - tab;
            end
            step_ff <= step_ff + 5'd1;
            if (step_ff == STEP_LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done    = done_ff;
   assign x_out   = x_ff;
   assign ang_out = a_ff;

endmodule

`default_nettype wire

// File: design/e2g_divsqrt.sv
// e2g_divsqrt: shared restoring divider (one quotient bit per cycle) and
// bitwise integer square root (one result bit per cycle). Depends on e2g_pkg.
`default_nettype none

module e2g_divsqrt (
   input  wire                         clock,
   input  wire                         reset,
   input  e2g_pkg::ds_ctl_type         ctl,
   input  wire [e2g_pkg::DIV_W-1:0]    num_in,
   input  wire [31:0]                  den_in,
   input  wire [63:0]                  rad_in,
   output logic                        done,
   output logic [e2g_pkg::DIV_W-1:0]   quotient,
   output logic [30:0]                 root
);
   import e2g_pkg::*;

   localparam logic [6:0] DIV_LAST  = 7'(DIV_W - 1);
   localparam logic [6:0] SQRT_LAST = 7'(SQRT_STEPS - 1);

   logic [DIV_W-1:0] num_ff;
   logic [31:0]      rem_ff, den_ff;
   logic [63:0]      v_ff, res_ff, bit_ff, sum;
   logic [32:0]      r, r_sub;
   logic [6:0]       cnt_ff;
   logic             op_ff, busy_ff, done_ff, div_ge, sq_ge;

   // one restoring step of each kind
   always_comb begin
      r      = {rem_ff, num_ff[DIV_W-1]};
      r_sub  = r - {1'b0, den_ff};
      div_ge = (r >= {1'b0, den_ff});
      sum    = res_ff + bit_ff;
      sq_ge  = (v_ff >= sum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.start) begin
            op_ff   <= ctl.op;
            num_ff  <= num_in;
            den_ff  <= den_in;
            rem_ff  <= '0;
            v_ff    <= rad_in;
            res_ff  <= '0;
            bit_ff  <= 64'd1 << 62;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 7'd1;
            if (op_ff == DS_DIV) begin
               rem_ff <= div_ge ? r_sub[31:0] : r[31:0];
               num_ff <= {num_ff[DIV_W-2:0], div_ge};
               if (cnt_ff == DIV_LAST) begin
                  busy_ff <= 1'b0;
                  done_ff <= 1'b1;
               end
            end else begin
               v_ff   <= sq_ge ? v_ff - sum : v_ff;
               res_ff <= sq_ge ? (res_ff >> 1) + bit_ff : res_ff >> 1;
               bit_ff <= bit_ff >> 2;
               if (cnt_ff == SQRT_LAST) begin
                  busy_ff <= 1'b0;
                  done_ff <= 1'b1;
               end
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = num_ff;
   assign root     = res_ff[30:0];

endmodule

`default_nettype wire

// File: design/ecef_to_geodetic_core.sv
// ecef_to_geodetic_core: top level, sequencer over shared multiplier,
// CORDIC engine and divide/sqrt unit. Depends on e2g_pkg, e2g_mul,
// e2g_cordic, e2g_divsqrt.
//
//   port group | direction | contents
//   req_*      | in        | x_pos, y_pos, z_pos position in mm
//   rsp_*      | out       | longitude, latitude, altitude, invalid, not_converged
//   csr_*      | in        | register index and write data (radius, flattening)
//
// One request at a time. Each pass of the latitude loop runs the CORDIC, a
// normalize shift loop, the two divides, the sqrt and five multiplies. A request
// runs up to MAX_ITERATIONS passes. An all-zero position goes from acceptance
// straight to S_OUT and the output register.
// Synchronous reset restores radius and flattening defaults and idles the
// sequencer. A finished response is held in the output register while the
// next request is computed; the core stalls only when that result is untaken.
`default_nettype none

module ecef_to_geodetic_core #(
   parameter int MAX_ITERATIONS = e2g_pkg::MAX_ITERATIONS_DEF,
   parameter int POS_WIDTH      = e2g_pkg::POS_WIDTH_DEF
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_ready,
   input  wire signed [POS_WIDTH-1:0]        req_x_pos,
   input  wire signed [POS_WIDTH-1:0]        req_y_pos,
   input  wire signed [POS_WIDTH-1:0]        req_z_pos,
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output logic signed [31:0]                rsp_longitude,
   output logic signed [31:0]                rsp_latitude,
   output logic signed [POS_WIDTH-1:0]       rsp_altitude,
   output logic                              rsp_invalid,
   output logic                              rsp_not_converged,
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire [e2g_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire [e2g_pkg::RADIUS_W-1:0]       csr_data
);
   import e2g_pkg::*;

   localparam int IT_W = $clog2(MAX_ITERATIONS);
   localparam logic [IT_W-1:0] IT_LAST = IT_W'(MAX_ITERATIONS - 1);
   localparam logic signed [63:0] COORD_LIM = 64'sd1 <<< 41;
   localparam logic signed [63:0] LIM_HI = (64'sd1 <<< (POS_WIDTH - 1)) - 64'sd1;
   localparam logic signed [63:0] LIM_LO = -LIM_HI - 64'sd1;
   localparam logic signed [ANG_W-1:0] HALF_PI = ANG_W'(64'sd1 <<< 30);
   localparam logic [63:0] N_CAP = 64'd1 << 55;
   localparam logic [32:0] ONE_Q32 = 33'd1 << 32;
   localparam logic [30:0] S_ONE = 31'd1 << 30;

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_E2   = 5'd1;
   localparam logic [4:0] S_CLON = 5'd2;
   localparam logic [4:0] S_GLON = 5'd3;
   localparam logic [4:0] S_DZ0  = 5'd4;
   localparam logic [4:0] S_ZDZ  = 5'd5;
   localparam logic [4:0] S_CLAT = 5'd6;
   localparam logic [4:0] S_GLAT = 5'd7;
   localparam logic [4:0] S_NORM = 5'd8;
   localparam logic [4:0] S_SDIV = 5'd9;
   localparam logic [4:0] S_SSQ  = 5'd10;
   localparam logic [4:0] S_T    = 5'd11;
   localparam logic [4:0] S_SQRT = 5'd12;
   localparam logic [4:0] S_NDIV = 5'd13;
   localparam logic [4:0] S_M1   = 5'd14;
   localparam logic [4:0] S_M2   = 5'd15;
   localparam logic [4:0] S_CHK  = 5'd16;
   localparam logic [4:0] S_FIN  = 5'd17;
   localparam logic [4:0] S_RND  = 5'd18;
   localparam logic [4:0] S_OUT  = 5'd19;

   // configuration registers
   logic [RADIUS_W-1:0] radius_ff;
   logic [FLAT_W-1:0]   flat_ff;

   // sequencer and data path registers
   logic [4:0]              state_ff;
   logic [IT_W-1:0]         it_ff;
   logic                    zero_ff, conv_ff;
   logic signed [63:0]      xq_ff, yq_ff, zq_ff, dz_ff, dzn_ff, zdz_ff, h_ff;
   logic [63:0]             zabs_ff, rho_ff, nh_ff, nq_ff, as_ff, nhs_ff;
   logic [32:0]             e2_ff;
   logic [30:0]             s_ff;
   logic [31:0]             lon_ff;
   logic signed [ANG_W-1:0] lat_ff;

   // unit launch registers
   logic               mul_go_ff, mul_frac_ff, cor_go_ff, ds_go_ff, ds_op_ff;
   logic [63:0]        mul_a_ff, ds_rad_ff;
   logic [32:0]        mul_b_ff;
   logic signed [63:0] cor_x_ff, cor_y_ff;
   logic [DIV_W-1:0]   ds_num_ff;
   logic [31:0]        ds_den_ff;

   // output register
   logic                      rsp_valid_ff, rsp_inv_ff, rsp_nc_ff;
   logic signed [31:0]        rsp_lon_ff, rsp_lat_ff;
   logic signed [POS_WIDTH-1:0] rsp_alt_ff;

   // unit results
   mul_ctl_type             mul_ctl;
   ds_ctl_type              ds_ctl;
   logic                    mul_done, cor_done, ds_done;
   logic [63:0]             mul_res;
   logic signed [63:0]      cor_x;
   logic signed [ANG_W-1:0] cor_ang;
   logic [DIV_W-1:0]        ds_quo;
   logic [30:0]             ds_root;

   // input conditioning
   logic signed [63:0] x_ext, y_ext, z_ext, x_cl, y_cl, z_cl;
   logic signed [63:0] zdz_next, diff, h_rnd, neg_r;
   logic [32:0]        w_raw;
   logic               in_zero, req_fire;
   logic signed [POS_WIDTH-1:0] alt_sat;

   assign mul_ctl = '{start: mul_go_ff, frac: mul_frac_ff};
   assign ds_ctl  = '{start: ds_go_ff, op: ds_op_ff};

   e2g_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mul_ctl),
      .a_in   (mul_a_ff),
      .b_in   (mul_b_ff),
      .done   (mul_done),
      .result (mul_res)
   );

   e2g_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cor_go_ff),
      .x_in    (cor_x_ff),
      .y_in    (cor_y_ff),
      .done    (cor_done),
      .x_out   (cor_x),
      .ang_out (cor_ang)
   );

   e2g_divsqrt u_ds (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ds_ctl),
      .num_in   (ds_num_ff),
      .den_in   (ds_den_ff),
      .rad_in   (ds_rad_ff),
      .done     (ds_done),
      .quotient (ds_quo),
      .root     (ds_root)
   );

   // clamp coordinates and other combinational helpers
   always_comb begin
      x_ext = 64'(req_x_pos);
      y_ext = 64'(req_y_pos);
      z_ext = 64'(req_z_pos);
      x_cl  = (x_ext > COORD_LIM) ? COORD_LIM : (x_ext < -COORD_LIM) ? -COORD_LIM : x_ext;
      y_cl  = (y_ext > COORD_LIM) ? COORD_LIM : (y_ext < -COORD_LIM) ? -COORD_LIM : y_ext;
      z_cl  = (z_ext > COORD_LIM) ? COORD_LIM : (z_ext < -COORD_LIM) ? -COORD_LIM : z_ext;
      in_zero  = (x_ext == 64'sd0) && (y_ext == 64'sd0) && (z_ext == 64'sd0);
      req_fire = req_valid && req_ready;
      zdz_next = zq_ff + dz_ff;
      w_raw    = ONE_Q32 - mul_res[32:0];
      diff     = dz_ff - dzn_ff;
      h_rnd    = (h_ff + 64'sd2048) >>> FRAC_BITS;
      neg_r    = 64'sd0 - signed'(64'(radius_ff));
      if (h_ff > LIM_HI) begin
         alt_sat = POS_WIDTH'(LIM_HI);
      end else if (h_ff < LIM_LO) begin
         alt_sat = POS_WIDTH'(LIM_LO);
      end else begin
         alt_sat = POS_WIDTH'(h_ff);
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
         flat_ff   <= FLAT_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == REG_RADIUS) begin
            radius_ff <= csr_data;
         end else if (csr_index == REG_FLAT) begin
            flat_ff <= csr_data[FLAT_W-1:0];
         end
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mul_go_ff    <= 1'b0;
         cor_go_ff    <= 1'b0;
         ds_go_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mul_go_ff <= 1'b0;
         cor_go_ff <= 1'b0;
         ds_go_ff  <= 1'b0;
         if (rsp_valid_ff && rsp_ready && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  xq_ff   <= x_cl <<< FRAC_BITS;
                  yq_ff   <= y_cl <<< FRAC_BITS;
                  zq_ff   <= z_cl <<< FRAC_BITS;
                  zero_ff <= in_zero;
                  if (in_zero) begin
                     lon_ff   <= '0;
                     lat_ff   <= '0;
                     conv_ff  <= 1'b1;
                     state_ff <= S_OUT;
                  end else begin
                     conv_ff     <= 1'b0;
                     mul_a_ff    <= 64'(flat_ff);
                     mul_b_ff    <= 33'(flat_ff);
                     mul_frac_ff <= 1'b0;
                     mul_go_ff   <= 1'b1;
                     state_ff    <= S_E2;
                  end
               end
            end
            S_E2: begin
               if (mul_done) begin
                  e2_ff     <= {flat_ff, 1'b0} - {1'b0, mul_res[63:32]};
                  cor_x_ff  <= xq_ff;
                  cor_y_ff  <= yq_ff;
                  cor_go_ff <= 1'b1;
                  state_ff  <= S_CLON;
               end
            end
            S_CLON: begin
               if (cor_done) begin
                  lon_ff      <= cor_ang[31:0];
                  mul_a_ff    <= cor_x;
                  mul_b_ff    <= INV_GAIN;
                  mul_frac_ff <= 1'b1;
                  mul_go_ff   <= 1'b1;
                  state_ff    <= S_GLON;
               end
            end
            S_GLON: begin
               if (mul_done) begin
                  rho_ff      <= mul_res;
                  mul_a_ff    <= (zq_ff < 0) ? -zq_ff : zq_ff;
                  mul_b_ff    <= e2_ff;
                  mul_frac_ff <= 1'b1;
                  mul_go_ff   <= 1'b1;
                  state_ff    <= S_DZ0;
               end
            end
            S_DZ0: begin
               if (mul_done) begin
                  dz_ff    <= (zq_ff < 0) ? -signed'(mul_res) : signed'(mul_res);
                  it_ff    <= '0;
                  state_ff <= S_ZDZ;
               end
            end
            // start of one refinement pass
            S_ZDZ: begin
               zdz_ff    <= zdz_next;
               cor_x_ff  <= signed'(rho_ff);
               cor_y_ff  <= zdz_next;
               cor_go_ff <= 1'b1;
               state_ff  <= S_CLAT;
            end
            S_CLAT: begin
               zabs_ff <= (zdz_ff < 0) ? -zdz_ff : zdz_ff;
               if (cor_done) begin
                  lat_ff      <= cor_ang;
                  mul_a_ff    <= cor_x;
                  mul_b_ff    <= INV_GAIN;
                  mul_frac_ff <= 1'b1;
                  mul_go_ff   <= 1'b1;
                  state_ff    <= S_GLAT;
               end
            end
            S_GLAT: begin
               if (mul_done) begin
                  nh_ff    <= mul_res;
                  nhs_ff   <= mul_res;
                  as_ff    <= (zabs_ff < mul_res) ? zabs_ff : mul_res;
                  state_ff <= S_NORM;
               end
            end
            // shift magnitude down one bit a cycle until it fits 32 bits
            S_NORM: begin
               if (nhs_ff[63:32] != 32'd0) begin
                  nhs_ff <= nhs_ff >> 1;
                  as_ff  <= as_ff >> 1;
               end else if (nhs_ff == 64'd0) begin
                  s_ff        <= '0;
                  mul_a_ff    <= '0;
                  mul_b_ff    <= '0;
                  mul_frac_ff <= 1'b0;
                  mul_go_ff   <= 1'b1;
                  state_ff    <= S_SSQ;
               end else begin
                  ds_num_ff <= DIV_W'(as_ff[31:0]) << 30;
                  ds_den_ff <= nhs_ff[31:0];
                  ds_op_ff  <= DS_DIV;
                  ds_go_ff  <= 1'b1;
                  state_ff  <= S_SDIV;
               end
            end
            S_SDIV: begin
               if (ds_done) begin
                  if (ds_quo > DIV_W'(S_ONE)) begin
                     s_ff     <= S_ONE;
                     mul_a_ff <= 64'(S_ONE);
                     mul_b_ff <= 33'(S_ONE);
                  end else begin
                     s_ff     <= ds_quo[30:0];
                     mul_a_ff <= 64'(ds_quo[30:0]);
                     mul_b_ff <= 33'(ds_quo[30:0]);
                  end
                  mul_frac_ff <= 1'b0;
                  mul_go_ff   <= 1'b1;
                  state_ff    <= S_SSQ;
               end
            end
            S_SSQ: begin
               if (mul_done) begin
                  mul_a_ff    <= 64'(mul_res[60:28]);
                  mul_b_ff    <= e2_ff;
                  mul_frac_ff <= 1'b1;
                  mul_go_ff   <= 1'b1;
                  state_ff    <= S_T;
               end
            end
            S_T: begin
               if (mul_done) begin
                  ds_rad_ff <= (w_raw == 33'd0) ? (64'd1 << 28) : (64'(w_raw) << 28);
                  ds_op_ff  <= DS_SQRT;
                  ds_go_ff  <= 1'b1;
                  state_ff  <= S_SQRT;
               end
            end
            S_SQRT: begin
               if (ds_done) begin
                  ds_num_ff <= DIV_W'(radius_ff) << (30 + FRAC_BITS);
                  ds_den_ff <= 32'(ds_root);
                  ds_op_ff  <= DS_DIV;
                  ds_go_ff  <= 1'b1;
                  state_ff  <= S_NDIV;
               end
            end
            // N in fixed point, capped for degenerate ellipsoids
            S_NDIV: begin
               if (ds_done) begin
                  if (ds_quo >= DIV_W'(N_CAP)) begin
                     nq_ff    <= N_CAP;
                     mul_a_ff <= N_CAP;
                  end else begin
                     nq_ff    <= ds_quo[63:0];
                     mul_a_ff <= ds_quo[63:0];
                  end
                  mul_b_ff    <= e2_ff;
                  mul_frac_ff <= 1'b1;
                  mul_go_ff   <= 1'b1;
                  state_ff    <= S_M1;
               end
            end
            S_M1: begin
               if (mul_done) begin
                  mul_a_ff    <= mul_res;
                  mul_b_ff    <= {s_ff, 2'b00};
                  mul_frac_ff <= 1'b1;
                  mul_go_ff   <= 1'b1;
                  state_ff    <= S_M2;
               end
            end
            S_M2: begin
               if (mul_done) begin
                  dzn_ff   <= (zdz_ff < 0) ? -signed'(mul_res) : signed'(mul_res);
                  state_ff <= S_CHK;
               end
            end
            // convergence test on the change of dZ
            S_CHK: begin
               if (diff >= -64'sd1 && diff <= 64'sd1) begin
                  conv_ff  <= 1'b1;
                  state_ff <= S_FIN;
               end else begin
                  dz_ff <= dzn_ff;
                  it_ff <= it_ff + 1'b1;
                  state_ff <= (it_ff == IT_LAST) ? S_FIN : S_ZDZ;
               end
            end
            S_FIN: begin
               h_ff <= signed'(nh_ff) - signed'(nq_ff);
               if (lat_ff > HALF_PI) begin
                  lat_ff <= HALF_PI;
               end else if (lat_ff < -HALF_PI) begin
                  lat_ff <= -HALF_PI;
               end
               state_ff <= S_RND;
            end
            S_RND: begin
               h_ff     <= h_rnd;
               state_ff <= S_OUT;
            end
            // hand off to the output register once it is free
            S_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_lon_ff   <= signed'(lon_ff);
                  rsp_lat_ff   <= lat_ff[31:0];
                  rsp_alt_ff   <= zero_ff ? neg_r[POS_WIDTH-1:0] : alt_sat;
                  rsp_inv_ff   <= zero_ff;
                  rsp_nc_ff    <= !conv_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready         = (state_ff == S_IDLE);
   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_longitude     = rsp_lon_ff;
   assign rsp_latitude      = rsp_lat_ff;
   assign rsp_altitude      = rsp_alt_ff;
   assign rsp_invalid       = rsp_inv_ff;
   assign rsp_not_converged = rsp_nc_ff;

   // a zero-vector response carries zero angles and a clear not_converged flag
   a_zero_resp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_invalid |->
         rsp_longitude == 32'sd0 && rsp_latitude == 32'sd0 && !rsp_not_converged)
      else $error("zero-vector response fields wrong");

   // latitude stays within +-pi/2
   a_lat_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_latitude <= 32'sd1073741824 && rsp_latitude >= -32'sd1073741824)
      else $error("latitude out of range");

   // after a request is taken the core is busy
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

endmodule

`default_nettype wire

// File: dv/ecef_to_geodetic_core_tb.sv
// ecef_to_geodetic_core_tb: self-checking bench for the ECEF to geodetic core.
// Predicts each fix in fixed point and compares it field by field on rsp_*.
// Depends on e2g_pkg and ecef_to_geodetic_core.
`default_nettype none

module ecef_to_geodetic_core_tb;
   import e2g_pkg::*;

   localparam int PW = POS_WIDTH_DEF;
   localparam int PASSES = MAX_ITERATIONS_DEF;
   localparam longint CYCLE_LIMIT = 8000000;
   localparam logic [CSR_IDX_W-1:0] REG_NONE = 8'd9;
   localparam logic [32:0] RADIUS_MAX = 33'h1_FFFF_FFFF;
   localparam logic [32:0] FLAT_MAX = 33'h0_FFFF_FFFF;
   localparam logic signed [PW-1:0] POS_MAX = {1'b0, {(PW-1){1'b1}}};
   localparam logic signed [PW-1:0] POS_MIN = {1'b1, {(PW-1){1'b0}}};
   localparam longint ANGLE_PI = 64'sd2147483648;
   localparam longint ANGLE_HALF = 64'sd1073741824;
   localparam logic [63:0] GAIN_INV = 64'd2608131496;

   // atan(2^-i), binary angle
   localparam longint ATAN_STEP [32] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
      10, 5, 3, 1, 1, 0};

   typedef struct {
      logic signed [31:0]   lon;
      logic signed [31:0]   lat;
      logic signed [PW-1:0] alt;
      logic                 invalid;
      logic                 not_conv;
   } fix_type;

   logic clock, reset;
   logic req_valid, req_ready;
   logic signed [PW-1:0] req_x_pos, req_y_pos, req_z_pos;
   logic rsp_valid, rsp_ready;
   logic signed [31:0] rsp_longitude, rsp_latitude;
   logic signed [PW-1:0] rsp_altitude;
   logic rsp_invalid, rsp_not_converged;
   logic csr_valid, csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [RADIUS_W-1:0] csr_data;

   logic [63:0] radius_mm, flat_q32;
   fix_type expected_fixes[$];
   int mismatches;
   longint cycles;
   bit quiet;

   ecef_to_geodetic_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_x_pos(req_x_pos), .req_y_pos(req_y_pos), .req_z_pos(req_z_pos),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_longitude(rsp_longitude), .rsp_latitude(rsp_latitude),
      .rsp_altitude(rsp_altitude), .rsp_invalid(rsp_invalid),
      .rsp_not_converged(rsp_not_converged),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // floor(a * b / 2^32)
   function automatic logic [63:0] mul_q32(input logic [63:0] a, input logic [63:0] b);
      return (a >> 32) * b + (((a & 64'hFFFF_FFFF) * b) >> 32);
   endfunction

   function automatic logic [63:0] int_sqrt(input logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // vectoring mode: gain-corrected magnitude and angle of (x0, y0)
   function automatic void cordic_vec(input longint x0, input longint y0,
                                      output longint mag, output longint ang);
      longint x, y, a, dx, dy;
      x = x0;
      y = y0;
      a = 0;
      if (x == 0 && y == 0) begin
         mag = 0;
         ang = 0;
         return;
      end
      if (x < 0) begin
         a = (y >= 0) ? ANGLE_PI : -ANGLE_PI;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < 32; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y > 0) begin
            x += dx; y -= dy; a += ATAN_STEP[i];
         end else begin
            x -= dx; y += dy; a -= ATAN_STEP[i];
         end
      end
      mag = longint'(mul_q32(x, GAIN_INV));
      ang = a;
   endfunction

   // expected fix for one position under the current ellipsoid
   function automatic fix_type predict_fix(input logic signed [PW-1:0] px,
                                           input logic signed [PW-1:0] py,
                                           input logic signed [PW-1:0] pz);
      fix_type r;
      longint xq, yq, zq, rho, lon, lat, dz, zdz, nh, nq, h, dzn, diff;
      logic [63:0] e2, a, s, w, t, sq, q, rem, m, u, nhu;
      int sh;
      bit conv;
      r.invalid = 1'b0;
      if (px == 0 && py == 0 && pz == 0) begin
         r.lon = 0; r.lat = 0; r.invalid = 1'b1; r.not_conv = 1'b0;
         r.alt = PW'(-longint'(radius_mm));
         return r;
      end
      xq = longint'(px) * 4096;
      yq = longint'(py) * 4096;
      zq = longint'(pz) * 4096;
      e2 = 2 * flat_q32 - ((flat_q32 * flat_q32) >> 32);
      cordic_vec(xq, yq, rho, lon);
      a = (zq < 0) ? -zq : zq;
      dz = longint'(mul_q32(a, e2));
      if (zq < 0) dz = -dz;
      lat = 0; nh = 0; nq = 0; conv = 0;
      for (int it = 0; it < PASSES; it++) begin
         zdz = zq + dz;
         cordic_vec(rho, zdz, nh, lat);
         nhu = nh;
         a = (zdz < 0) ? -zdz : zdz;
         if (a > nhu) a = nhu;
         if (nhu == 0) begin
            s = 0;
         end else begin
            sh = 0;
            while ((nhu >> sh) >= 64'h1_0000_0000) sh++;
            s = ((a >> sh) << 30) / (nhu >> sh);
            if (s > (64'd1 << 30)) s = 64'd1 << 30;
         end
         t = mul_q32((s * s) >> 28, e2);
         w = (64'd1 << 32) - t;
         if (w < 1) w = 1;
         sq = int_sqrt(w << 28);
         q = (radius_mm << 30) / sq;
         rem = (radius_mm << 30) % sq;
         if (q >= (64'd1 << 43)) nq = longint'(64'd1 << 55);
         else nq = longint'((q << 12) + ((rem << 12) / sq));
         m = mul_q32(mul_q32(nq, e2), s << 2);
         dzn = (zdz < 0) ? -longint'(m) : longint'(m);
         diff = dz - dzn;
         if (diff >= -1 && diff <= 1) begin
            conv = 1;
            break;
         end
         dz = dzn;
      end
      if (lat > ANGLE_HALF) lat = ANGLE_HALF;
      if (lat < -ANGLE_HALF) lat = -ANGLE_HALF;
      // round half up to whole mm, then saturate
      h = nh - nq;
      u = h + 64'sd2048 + (64'sd1 <<< 60);
      h = longint'(u >> 12) - (64'sd1 <<< 48);
      if (h > longint'(POS_MAX)) h = longint'(POS_MAX);
      if (h < longint'(POS_MIN)) h = longint'(POS_MIN);
      r.lon = lon[31:0];
      r.lat = lat[31:0];
      r.alt = h[PW-1:0];
      r.not_conv = !conv;
      return r;
   endfunction

   // one request; an optional gap lowers valid first
   task automatic send_position(input logic signed [PW-1:0] px,
                                input logic signed [PW-1:0] py,
                                input logic signed [PW-1:0] pz);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_x_pos <= px;
      req_y_pos <= py;
      req_z_pos <= pz;
      do @(posedge clock); while (!req_ready);
      expected_fixes.push_back(predict_fix(px, py, pz));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_fixes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [32:0] val);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == REG_RADIUS) radius_mm = 64'(val);
      else if (idx == REG_FLAT) flat_q32 = 64'(val[31:0]);
      @(posedge clock);
   endtask

   function automatic logic signed [PW-1:0] rand_pos(input int mode);
      logic signed [PW-1:0] v;
      case (mode)
         0: v = PW'({$urandom, $urandom});
         1: v = PW'($signed($urandom_range(0, 2000)) - 1000);
         default: v = {{(PW-33){$urandom_range(0, 1) == 1}}, 1'b0, $urandom};
      endcase
      return v;
   endfunction

   task automatic send_random_position();
      int kind;
      kind = $urandom_range(0, 99);
      if (kind < 60)
         send_position(rand_pos(2), rand_pos(2), rand_pos(2));
      else if (kind < 80)
         send_position(rand_pos(0), rand_pos(0), rand_pos(0));
      else if (kind < 88)
         send_position(rand_pos(1), rand_pos(1), rand_pos(1));
      else if (kind < 94)
         send_position(0, 0, rand_pos($urandom_range(0, 2)));
      else if (kind < 98)
         send_position(rand_pos(2), rand_pos(2), 0);
      else
         send_position(0, 0, 0);
   endtask

   task automatic test_directed_points();
      send_position(0, 0, 0);
      send_position(0, 0, PW'(64'sd6356752314));
      send_position(0, 0, PW'(-64'sd6356752314));
      send_position(PW'(64'sd6378137000), 0, 0);
      send_position(PW'(-64'sd6378137000), 0, 0);
      send_position(PW'(-64'sd6378137000), -1, 0);
      send_position(0, PW'(64'sd6378137000), 0);
      send_position(0, PW'(-64'sd6378137000), 0);
      send_position(POS_MAX, POS_MAX, POS_MAX);
      send_position(POS_MIN, POS_MIN, POS_MIN);
      send_position(POS_MAX, POS_MIN, 0);
      send_position(-1, -1, -1);
      send_position(1, 0, 0);
      send_position(PW'(64'sd4510731000), PW'(64'sd4510731000), PW'(64'sd4487348000));
   endtask

   task automatic test_ellipsoid_extremes();
      logic [32:0] radii [4];
      logic [32:0] flats [4];
      radii = '{33'd1, RADIUS_MAX, 33'd0, RADIUS_RESET};
      flats = '{33'd0, FLAT_MAX, 33'd14400212, FLAT_MAX};
      write_reg(REG_NONE, 33'h1_2345_6789);
      for (int k = 0; k < 4; k++) begin
         write_reg(REG_RADIUS, radii[k]);
         write_reg(REG_FLAT, flats[k]);
         send_position(0, 0, 0);
         send_position(0, 0, PW'(64'sd6356752314));
         send_position(1, 0, PW'(-64'sd6356752314));
         send_position(PW'(64'sd4000000000), PW'(-64'sd3000000000), PW'(64'sd4000000000));
         send_position(POS_MAX, POS_MIN, POS_MAX);
      end
   endtask

   task automatic test_random_positions();
      for (int n = 0; n < 1000; n++) begin
         if (n % 200 == 0) begin
            write_reg(REG_RADIUS, ($urandom_range(0, 3) == 0) ? 33'({$urandom, $urandom})
                                  : 33'd6300000000 + $urandom_range(0, 200000000));
            write_reg(REG_FLAT, ($urandom_range(0, 3) == 0) ? 33'($urandom)
                                : 33'($urandom_range(0, 50000000)));
         end
         if (n == 850) quiet = 1;
         send_random_position();
      end
   endtask

   // result checker
   always @(posedge clock) begin
      fix_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_fixes.size() == 0) begin
            $display("%0t unexpected response lon=%0d lat=%0d alt=%0d",
                     $time, rsp_longitude, rsp_latitude, rsp_altitude);
            mismatches++;
         end else begin
            e = expected_fixes.pop_front();
            if (rsp_longitude !== e.lon) begin
               $display("%0t longitude exp %0d got %0d", $time, e.lon, rsp_longitude);
               mismatches++;
            end
            if (rsp_latitude !== e.lat) begin
               $display("%0t latitude exp %0d got %0d", $time, e.lat, rsp_latitude);
               mismatches++;
            end
            if (rsp_altitude !== e.alt) begin
               $display("%0t altitude exp %0d got %0d", $time, e.alt, rsp_altitude);
               mismatches++;
            end
            if (rsp_invalid !== e.invalid) begin
               $display("%0t invalid exp %0d got %0d", $time, e.invalid, rsp_invalid);
               mismatches++;
            end
            if (rsp_not_converged !== e.not_conv) begin
               $display("%0t not_converged exp %0d got %0d", $time, e.not_conv,
                        rsp_not_converged);
               mismatches++;
            end
         end
      end
   end

   // response-side stall bursts
   initial begin
      rsp_ready = 1'b0;
      forever begin
         if (!quiet && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[ecef_to_geodetic_core] ERROR");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_x_pos = '0;
      req_y_pos = '0;
      req_z_pos = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      radius_mm = 64'(RADIUS_RESET);
      flat_q32 = 64'(FLAT_RESET);
      mismatches = 0;
      cycles = 0;
      quiet = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_points();
      test_ellipsoid_extremes();
      test_random_positions();
      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("[ecef_to_geodetic_core] OK");
      else
         $display("[ecef_to_geodetic_core] ERROR");
      $finish;
   end

endmodule

`default_nettype wire

// File: ecef_to_geodetic_core.f
design/e2g_pkg.sv
design/e2g_mul.sv
design/e2g_cordic.sv
design/e2g_divsqrt.sv
design/ecef_to_geodetic_core.sv
dv/ecef_to_geodetic_core_tb.sv
